FILE: rtl/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants of the floppy controller register block.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam logic [12:0] TRACK_WRITE_LIMIT = 13'd6125;
  localparam logic [7:0]  LAST_TRACK        = 8'd79;
  localparam logic [31:0] INDEX_PERIOD      = 32'd200000;
  localparam logic [31:0] INDEX_WIDTH       = 32'd3000;
  localparam logic [31:0] RADDR_TIMEOUT     = 32'd300000;

  localparam logic [1:0] REG_CMD  = 2'd0;
  localparam logic [1:0] REG_TRK  = 2'd1;
  localparam logic [1:0] REG_SEC  = 2'd2;
  localparam logic [1:0] REG_DATA = 2'd3;

  localparam logic [1:0] CFG_DRIVE = 2'd0;
  localparam logic [1:0] CFG_HEAD  = 2'd1;
  localparam logic [1:0] CFG_SPT   = 2'd2;
  localparam logic [1:0] CFG_SSC   = 2'd3;

  localparam logic [2:0] MOP_NONE      = 3'd0;
  localparam logic [2:0] MOP_START     = 3'd1;
  localparam logic [2:0] MOP_CONSUME   = 3'd2;
  localparam logic [2:0] MOP_WRITE     = 3'd3;

  localparam logic [3:0] CMD_RESTORE = 4'h0;
  localparam logic [3:0] CMD_SEEK    = 4'h1;
  localparam logic [3:0] CMD_RD      = 4'h8;
  localparam logic [3:0] CMD_RD_M    = 4'h9;
  localparam logic [3:0] CMD_WR      = 4'hA;
  localparam logic [3:0] CMD_WR_M    = 4'hB;
  localparam logic [3:0] CMD_RADDR   = 4'hC;
  localparam logic [3:0] CMD_FINT    = 4'hD;
  localparam logic [3:0] CMD_WTRK    = 4'hF;

  localparam logic [7:0] MARK_ID   = 8'hFE;
  localparam logic [7:0] MARK_DATA = 8'hFB;
  localparam logic [7:0] MARK_CRC  = 8'hF7;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_ID   = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] reg_addr;
    logic [7:0] write_value;
    logic [31:0] time_us;
    logic       drive_attached;
    logic       media_present;
    logic       write_protect;
    logic [7:0] media_byte;
    logic       media_last_byte;
    logic [7:0] media_sector_under_head;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       drq;
    logic [2:0] media_op;
    logic [7:0] media_sector_index;
    logic [7:0] media_track;
    logic       media_head;
    logic [7:0] media_write_byte;
    logic [1:0] media_drive;
  } out_item_t;

  typedef struct packed {
    logic [1:0] drive_select;
    logic       head_select;
    logic [7:0] sectors_per_track;
    logic [1:0] sector_size_code;
  } cfg_t;

endpackage

FILE: rtl/fdc_core.sv
// ----------------------------------------------------------------------------
// fdc_core
// Controller state and single-pass access logic: takes the registered access,
// updates the register file and produces the result item.
// ----------------------------------------------------------------------------
module fdc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              act,
  input  fdc_pkg::in_item_t item,
  input  fdc_pkg::cfg_t     cfg,
  output fdc_pkg::out_item_t res
);

  fdc_pkg::mode_t  mode_r, mode_nxt;
  fdc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  track_r, track_nxt, sector_r, sector_nxt, data_r, data_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        stepin_r, stepin_nxt, irq_r, irq_nxt, gvalid_r, gvalid_nxt;
  logic [31:0] ctime_r, ctime_nxt;
  logic [3:0]  lastcmd_r, lastcmd_nxt;
  logic [2:0]  idleft_r, idleft_nxt;
  logic [7:0]  idsec_r, idsec_nxt;
  logic [7:0]  idtrk_r, idtrk_nxt;
  logic        idhd_r, idhd_nxt;
  logic [12:0] tbw_r, tbw_nxt;
  logic [7:0]  gf_r [4];
  logic [7:0]  gf_nxt [4];
  logic [2:0]  gcnt_r, gcnt_nxt;
  logic [10:0] sbd_r, sbd_nxt;

  logic        start;
  logic [7:0]  st_idx, wbyte, rd, idb;
  logic [2:0]  opc;
  logic [3:0]  c;
  logic [17:0] tmod;
  logic [31:0] tq;
  logic [47:0] tprod;
  logic [31:0] tdiff;
  logic [12:0] tbw_inc;
  logic [10:0] sec_size;
  logic [2:0]  idk;

  // time mod 200000 via reciprocal multiply and one correction
  assign tprod = {16'd0, item.time_us} * 48'd21474;
  always_comb begin
    tq = 32'(tprod >> 32);
    tdiff = item.time_us - tq * fdc_pkg::INDEX_PERIOD;
    if (tdiff >= fdc_pkg::INDEX_PERIOD) tdiff = tdiff - fdc_pkg::INDEX_PERIOD;
    tmod = tdiff[17:0];
  end

  assign sec_size = 11'd128 << cfg.sector_size_code;
  assign c = item.write_value[7:4];
  assign idk = 3'd6 - idleft_r;

  always_comb begin
    case (idk)
      3'd0:    idb = idtrk_r;
      3'd1:    idb = {7'd0, idhd_r};
      3'd2:    idb = idsec_r;
      3'd3:    idb = 8'h03;
      default: idb = 8'h00;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r; phase_nxt = phase_r; track_nxt = track_r;
    sector_nxt = sector_r; data_nxt = data_r; status_nxt = status_r;
    stepin_nxt = stepin_r; irq_nxt = irq_r; gvalid_nxt = gvalid_r;
    ctime_nxt = ctime_r; lastcmd_nxt = lastcmd_r; idleft_nxt = idleft_r;
    idsec_nxt = idsec_r; idtrk_nxt = idtrk_r; idhd_nxt = idhd_r;
    tbw_nxt = tbw_r; gf_nxt = gf_r; gcnt_nxt = gcnt_r;
    sbd_nxt = sbd_r;
    start = 1'b0; st_idx = 8'd0; wbyte = 8'd0; opc = fdc_pkg::MOP_NONE;
    rd = 8'd0; tbw_inc = 13'd0;
    if (item.kind) begin
      case (item.reg_addr)
        fdc_pkg::REG_CMD: begin
          lastcmd_nxt = c;
          case (c) inside
            fdc_pkg::CMD_RESTORE: begin
              track_nxt = 8'd0; stepin_nxt = 1'b0; mode_nxt = fdc_pkg::MODE_WAIT;
              status_nxt = 8'h01; irq_nxt = 1'b1;
            end
            fdc_pkg::CMD_SEEK: begin
              track_nxt = (data_r > fdc_pkg::LAST_TRACK) ? fdc_pkg::LAST_TRACK : data_r;
              status_nxt = 8'h01; irq_nxt = 1'b1;
            end
            [4'h2:4'h7]: begin
              logic sin;
              sin = (c >= 4'h4) ? (c < 4'h6) : stepin_r;
              stepin_nxt = sin;
              if (sin) begin
                if (track_r < fdc_pkg::LAST_TRACK) track_nxt = track_r + 8'd1;
              end else if (track_r != 8'd0) track_nxt = track_r - 8'd1;
              status_nxt = 8'h01; irq_nxt = 1'b1;
            end
            [fdc_pkg::CMD_RD:fdc_pkg::CMD_WR_M]: begin
              if (item.drive_attached) begin
                if (c >= fdc_pkg::CMD_WR && item.write_protect) status_nxt = 8'h40;
                else if (sector_r <= cfg.sectors_per_track) begin
                  start = 1'b1; st_idx = sector_r - 8'd1;
                  mode_nxt = (c >= fdc_pkg::CMD_WR) ? fdc_pkg::MODE_WRITE
                                                    : fdc_pkg::MODE_READ;
                  status_nxt = 8'h03;
                end else begin
                  mode_nxt = fdc_pkg::MODE_WAIT;
                  status_nxt = (c >= fdc_pkg::CMD_WR) ? 8'h80 : 8'h10;
                end
              end
            end
            fdc_pkg::CMD_RADDR: begin
              if (item.drive_attached) begin
                // capture the ID as it stands when the command is issued
                idsec_nxt = item.media_sector_under_head + 8'd1;
                idtrk_nxt = track_r; idhd_nxt = cfg.head_select;
                idleft_nxt = 3'd6; mode_nxt = fdc_pkg::MODE_READ;
                status_nxt = 8'h03; ctime_nxt = item.time_us;
              end
            end
            fdc_pkg::CMD_FINT: begin
              mode_nxt = fdc_pkg::MODE_WAIT; idleft_nxt = 3'd0; status_nxt = 8'h01;
            end
            fdc_pkg::CMD_WTRK: begin
              mode_nxt = fdc_pkg::MODE_WRITE; phase_nxt = fdc_pkg::PH_NONE;
              tbw_nxt = 13'd0; gvalid_nxt = 1'b0;
              for (int i = 0; i < 4; i++) gf_nxt[i] = 8'd0;
              gcnt_nxt = 3'd0; status_nxt = 8'h03;
            end
            default: ;
          endcase
        end
        fdc_pkg::REG_TRK: track_nxt = item.write_value;
        fdc_pkg::REG_SEC: sector_nxt = item.write_value;
        default: begin
          data_nxt = item.write_value;
          if (item.drive_attached && mode_r == fdc_pkg::MODE_WRITE) begin
            if (lastcmd_r == fdc_pkg::CMD_WTRK) begin
              tbw_inc = 13'd1;
              if (item.write_value == fdc_pkg::MARK_ID) phase_nxt = fdc_pkg::PH_ID;
              else if (item.write_value == fdc_pkg::MARK_DATA)
                phase_nxt = fdc_pkg::PH_DATA;
              else if (item.write_value == fdc_pkg::MARK_CRC) tbw_inc = 13'd2;
              else if (phase_r == fdc_pkg::PH_ID) begin
                gf_nxt[gcnt_r[1:0]] = item.write_value;
                if (gcnt_r >= 3'd3) begin
                  logic ok;
                  ok = gf_r[0] == track_r && gf_r[1] == {7'd0, cfg.head_select} &&
                       item.write_value[1:0] == cfg.sector_size_code &&
                       gf_r[2] <= cfg.sectors_per_track;
                  gcnt_nxt = 3'd0; gvalid_nxt = ok;
                  if (ok) begin start = 1'b1; st_idx = gf_r[2] - 8'd1; end
                  phase_nxt = fdc_pkg::PH_NONE; sbd_nxt = 11'd0;
                end else gcnt_nxt = gcnt_r + 3'd1;
              end else if (phase_r == fdc_pkg::PH_DATA && gvalid_r) begin
                opc = fdc_pkg::MOP_WRITE; wbyte = item.write_value;
                if (sbd_r + 11'd1 == sec_size) begin
                  sbd_nxt = 11'd0; gvalid_nxt = 1'b0; phase_nxt = fdc_pkg::PH_NONE;
                end else sbd_nxt = sbd_r + 11'd1;
              end
              tbw_nxt = tbw_r + tbw_inc;
              if (tbw_nxt < fdc_pkg::TRACK_WRITE_LIMIT) status_nxt = 8'h03;
              else begin
                mode_nxt = fdc_pkg::MODE_WAIT; status_nxt = 8'h00; irq_nxt = 1'b1;
              end
            end else begin
              opc = fdc_pkg::MOP_WRITE; wbyte = item.write_value;
              if (item.media_last_byte) begin
                if (lastcmd_r == fdc_pkg::CMD_WR_M) begin
                  start = 1'b1; st_idx = sector_r; sector_nxt = sector_r + 8'd1;
                  status_nxt = 8'h03;
                end else begin
                  mode_nxt = fdc_pkg::MODE_WAIT; status_nxt = 8'h00;
                end
              end
            end
          end
        end
      endcase
    end else begin
      case (item.reg_addr)
        fdc_pkg::REG_CMD: begin
          logic [7:0] s;
          logic t1;
          irq_nxt = 1'b0;
          t1 = lastcmd_r <= 4'h7 || lastcmd_r == fdc_pkg::CMD_FINT;
          s = status_r;
          s[7] = !item.drive_attached || !item.media_present;
          if (t1) s[1] = tmod < fdc_pkg::INDEX_WIDTH[17:0];
          if (lastcmd_r == fdc_pkg::CMD_RADDR &&
              (item.time_us - ctime_r) > fdc_pkg::RADDR_TIMEOUT) s[0] = 1'b0;
          rd = s; status_nxt = s;
          if (lastcmd_r == fdc_pkg::CMD_RESTORE) status_nxt = 8'h24;
          else if (t1) status_nxt = (track_r == 8'd0) ? 8'h24 : 8'h20;
        end
        fdc_pkg::REG_TRK: rd = track_r;
        fdc_pkg::REG_SEC: rd = sector_r;
        default: begin
          logic [7:0] s;
          s = status_r;
          if (mode_r == fdc_pkg::MODE_WAIT) s[1] = 1'b0;
          status_nxt = s;
          rd = data_r;
          if (mode_r == fdc_pkg::MODE_READ) begin
            if (idleft_r != 3'd0) begin
              data_nxt = idb; rd = idb; idleft_nxt = idleft_r - 3'd1;
              if (idleft_r == 3'd1) begin
                mode_nxt = fdc_pkg::MODE_WAIT; status_nxt = 8'h00;
              end
            end else if (item.drive_attached) begin
              data_nxt = item.media_byte; rd = item.media_byte;
              opc = fdc_pkg::MOP_CONSUME;
              if (item.media_last_byte) begin
                if (lastcmd_r == fdc_pkg::CMD_RD_M) begin
                  start = 1'b1; st_idx = sector_r; sector_nxt = sector_r + 8'd1;
                  status_nxt = 8'h01;
                end else begin
                  mode_nxt = fdc_pkg::MODE_WAIT; status_nxt = 8'h00;
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res.read_data = rd;
    res.irq = irq_nxt;
    res.drq = mode_nxt != fdc_pkg::MODE_WAIT;
    res.media_op = start ? ((opc == fdc_pkg::MOP_NONE) ? fdc_pkg::MOP_START
                                                       : opc + 3'd2) : opc;
    res.media_sector_index = start ? st_idx : 8'd0;
    res.media_track = start ? track_r : 8'd0;
    res.media_head = start ? cfg.head_select : 1'b0;
    res.media_write_byte = wbyte;
    res.media_drive = (res.media_op != fdc_pkg::MOP_NONE) ? cfg.drive_select : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fdc_pkg::MODE_WAIT; phase_r <= fdc_pkg::PH_NONE;
      track_r <= 8'd0; sector_r <= 8'd1; data_r <= 8'd0; status_r <= 8'd0;
      stepin_r <= 1'b1; irq_r <= 1'b0; gvalid_r <= 1'b0; ctime_r <= 32'd0;
      lastcmd_r <= 4'd0; idleft_r <= 3'd0; idsec_r <= 8'd0; tbw_r <= 13'd0;
      idtrk_r <= 8'd0; idhd_r <= 1'b0;
      for (int i = 0; i < 4; i++) gf_r[i] <= 8'd0;
      gcnt_r <= 3'd0; sbd_r <= 11'd0;
    end else if (act) begin
      mode_r <= mode_nxt; phase_r <= phase_nxt; track_r <= track_nxt;
      sector_r <= sector_nxt; data_r <= data_nxt; status_r <= status_nxt;
      stepin_r <= stepin_nxt; irq_r <= irq_nxt; gvalid_r <= gvalid_nxt;
      ctime_r <= ctime_nxt; lastcmd_r <= lastcmd_nxt; idleft_r <= idleft_nxt;
      idsec_r <= idsec_nxt; tbw_r <= tbw_nxt; gf_r <= gf_nxt;
      idtrk_r <= idtrk_nxt; idhd_r <= idhd_nxt;
      gcnt_r <= gcnt_nxt; sbd_r <= sbd_nxt;
    end
  end

  a_gcnt: assert property (@(posedge clk) disable iff (!rst_n) gcnt_r <= 3'd3)
    else $error("gap id count out of range");
  a_idleft: assert property (@(posedge clk) disable iff (!rst_n) idleft_r <= 3'd6)
    else $error("id bytes count out of range");
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    act && res.media_op == fdc_pkg::MOP_NONE |-> res.media_drive == 2'd0)
    else $error("drive driven without media op");

endmodule

FILE: rtl/floppy_disk_controller_registers_top.sv
// ----------------------------------------------------------------------------
// floppy_disk_controller_registers_top
// An accepted access is held in the input register, which feeds the single-pass
// logic that loads the result register.
// Throughput: one access per cycle; the result register and input register
// advance together whenever the result stage is free or being drained.
// Reset: synchronous active-low; returns the controller state and config to their reset values.
// ----------------------------------------------------------------------------
module floppy_disk_controller_registers_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fdc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  fdc_pkg::cfg_t      cfg_r;
  fdc_pkg::in_item_t  in_r;
  logic               inv_r, outv_r;
  fdc_pkg::out_item_t res, out_r;
  logic               adv;

  // result stage takes the staged access when it is empty or being drained
  assign adv = !outv_r || out_ready;
  assign in_ready = adv || !inv_r;

  fdc_core u_core (.clk(clk), .rst_n(rst_n), .act(inv_r && adv), .item(in_r),
                   .cfg(cfg_r), .res(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{drive_select: 2'd0, head_select: 1'b0,
                 sectors_per_track: 8'd5, sector_size_code: 2'd3};
      inv_r <= 1'b0; outv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdc_pkg::CFG_DRIVE: cfg_r.drive_select <= cfg_wdata[1:0];
          fdc_pkg::CFG_HEAD:  cfg_r.head_select <= cfg_wdata[0];
          fdc_pkg::CFG_SPT:   cfg_r.sectors_per_track <= cfg_wdata;
          default:            cfg_r.sector_size_code <= cfg_wdata[1:0];
        endcase
      end
      if (adv) outv_r <= inv_r;
      if (in_ready) inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_r <= in_data;
    if (adv && inv_r) out_r <= res;
  end

  assign out_valid = outv_r;
  assign out_data = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    inv_r && !adv |=> inv_r)
    else $error("staged access lost");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !inv_r |-> in_ready)
    else $error("stalled with empty input stage");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the floppy controller register block. A directed
// table covers reset values, every command class and the corner cases, then
// sequences of register accesses with random content run under several
// drive/head/geometry settings and handshake idle patterns. Every result is
// compared with an in-bench model of the controller or with a fixed expectation of its directed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ACCESSES = 1100;
  localparam int NUM_PHASES = 8;

  localparam logic [3:0] CMD_STEP     = 4'h2;
  localparam logic [3:0] CMD_STEP_IN  = 4'h4;
  localparam logic [3:0] CMD_STEP_OUT = 4'h6;
  localparam logic [3:0] CMD_SPARE    = 4'hE;

  localparam logic [7:0] ST_BUSY     = 8'h01;
  localparam logic [7:0] ST_DRQ_IDX  = 8'h02;
  localparam logic [7:0] ST_RNF      = 8'h10;
  localparam logic [7:0] ST_WPROT    = 8'h40;
  localparam logic [7:0] ST_NOT_RDY  = 8'h80;
  localparam logic [7:0] ST_IDLE     = 8'h20;
  localparam logic [7:0] ST_IDLE_TK0 = 8'h24;
  localparam logic [7:0] ST_ACTIVE   = 8'h03;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  fdc_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  fdc_pkg::out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  floppy_disk_controller_registers_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // controller model state
  logic [1:0]  c_drive;
  logic        c_head;
  logic [7:0]  c_spt;
  logic [1:0]  c_ssc;
  fdc_pkg::mode_t  m_mode;
  fdc_pkg::phase_t m_phase;
  logic [7:0]  m_trk, m_sec, m_dat, m_sts;
  logic        m_step_in, m_irq, m_gid_valid;
  logic [31:0] m_cmd_time;
  logic [3:0]  m_last_cmd;
  int          m_id_left, m_gid_cnt, m_trk_bytes, m_sec_done;
  logic [7:0]  m_id_buf [6];
  logic [7:0]  m_gid [4];

  // media request of the current transaction
  logic [2:0]  op_code;
  logic        op_start;
  logic [7:0]  op_idx, op_trk, op_wb;
  logic        op_hd;

  fdc_pkg::out_item_t pending_results [$];
  int          mismatch_count;
  int          accesses_sent;
  int          results_checked;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          idle_cycles;

  typedef struct {
    fdc_pkg::in_item_t  acc;
    bit                 typed;
    fdc_pkg::out_item_t exp;
  } dir_row_t;
  dir_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_model();
    c_drive = '0; c_head = 1'b0; c_spt = 8'd5; c_ssc = 2'd3;
    m_mode = fdc_pkg::MODE_WAIT; m_phase = fdc_pkg::PH_NONE;
    m_trk = '0; m_sec = 8'd1; m_dat = '0; m_sts = '0;
    m_step_in = 1'b1; m_irq = 1'b0; m_gid_valid = 1'b0;
    m_cmd_time = '0; m_last_cmd = fdc_pkg::CMD_RESTORE;
    m_id_left = 0; m_gid_cnt = 0; m_trk_bytes = 0; m_sec_done = 0;
    foreach (m_id_buf[i]) m_id_buf[i] = '0;
    foreach (m_gid[i]) m_gid[i] = '0;
  endtask

  function void media_start(logic [7:0] idx);
    op_start = 1'b1;
    op_idx = idx;
    op_trk = m_trk;
    op_hd = c_head;
  endfunction

  task automatic predict_access(input fdc_pkg::in_item_t it, output fdc_pkg::out_item_t r);
    logic [7:0]  v, rd;
    logic [3:0]  c;
    logic        type1;
    logic [31:0] dt;
    v = it.write_value;
    rd = '0;
    op_code = fdc_pkg::MOP_NONE; op_start = 1'b0;
    op_idx = '0; op_trk = '0; op_hd = 1'b0; op_wb = '0;
    if (it.kind) begin
      case (it.reg_addr)
        fdc_pkg::REG_CMD: begin
          c = v[7:4];
          m_last_cmd = c;
          case (c)
            fdc_pkg::CMD_RESTORE: begin
              m_trk = '0; m_step_in = 1'b0; m_mode = fdc_pkg::MODE_WAIT;
              m_sts = ST_BUSY; m_irq = 1'b1;
            end
            fdc_pkg::CMD_SEEK: begin
              m_trk = (m_dat > fdc_pkg::LAST_TRACK) ? fdc_pkg::LAST_TRACK : m_dat;
              m_sts = ST_BUSY; m_irq = 1'b1;
            end
            fdc_pkg::CMD_RD, fdc_pkg::CMD_RD_M, fdc_pkg::CMD_WR, fdc_pkg::CMD_WR_M: begin
              if (it.drive_attached) begin
                if (c >= fdc_pkg::CMD_WR && it.write_protect) begin
                  m_sts = ST_WPROT;
                end else if (m_sec <= c_spt) begin
                  media_start(m_sec - 8'd1);
                  m_mode = (c >= fdc_pkg::CMD_WR) ? fdc_pkg::MODE_WRITE : fdc_pkg::MODE_READ;
                  m_sts = ST_ACTIVE;
                end else begin
                  m_mode = fdc_pkg::MODE_WAIT;
                  m_sts = (c >= fdc_pkg::CMD_WR) ? ST_NOT_RDY : ST_RNF;
                end
              end
            end
            fdc_pkg::CMD_RADDR: begin
              if (it.drive_attached) begin
                m_id_buf[0] = m_trk;
                m_id_buf[1] = {7'd0, c_head};
                m_id_buf[2] = it.media_sector_under_head + 8'd1;
                m_id_buf[3] = 8'd3; m_id_buf[4] = '0; m_id_buf[5] = '0;
                m_id_left = 6;
                m_mode = fdc_pkg::MODE_READ;
                m_sts = ST_ACTIVE;
                m_cmd_time = it.time_us;
              end
            end
            fdc_pkg::CMD_FINT: begin
              m_mode = fdc_pkg::MODE_WAIT; m_id_left = 0; m_sts = ST_BUSY;
            end
            fdc_pkg::CMD_WTRK: begin
              m_mode = fdc_pkg::MODE_WRITE; m_phase = fdc_pkg::PH_NONE; m_trk_bytes = 0;
              m_gid_valid = 1'b0;
              foreach (m_gid[i]) m_gid[i] = '0;
              m_gid_cnt = 0;
              m_sts = ST_ACTIVE;
            end
            default: begin
              if (c >= CMD_STEP && c < fdc_pkg::CMD_RD) begin
                if (c >= CMD_STEP_IN) m_step_in = (c < CMD_STEP_OUT);
                if (m_step_in) begin
                  if (m_trk < fdc_pkg::LAST_TRACK) m_trk = m_trk + 8'd1;
                end else if (m_trk > 0) begin
                  m_trk = m_trk - 8'd1;
                end
                m_sts = ST_BUSY; m_irq = 1'b1;
              end
            end
          endcase
        end
        fdc_pkg::REG_TRK: m_trk = v;
        fdc_pkg::REG_SEC: m_sec = v;
        default: begin
          m_dat = v;
          if (it.drive_attached && m_mode == fdc_pkg::MODE_WRITE) begin
            if (m_last_cmd == fdc_pkg::CMD_WTRK) begin
              // parse the formatting stream: ID mark, ID fields, data mark, data
              if (v == fdc_pkg::MARK_ID) begin
                m_phase = fdc_pkg::PH_ID;
              end else if (v == fdc_pkg::MARK_DATA) begin
                m_phase = fdc_pkg::PH_DATA;
              end else if (v == fdc_pkg::MARK_CRC) begin
                m_trk_bytes++;
              end else if (m_phase == fdc_pkg::PH_ID) begin
                m_gid[m_gid_cnt & 3] = v;
                m_gid_cnt++;
                if (m_gid_cnt >= 4) begin
                  m_gid_cnt = 0;
                  m_gid_valid = (m_gid[0] == m_trk) && (m_gid[1] == {7'd0, c_head}) &&
                                (m_gid[3][1:0] == c_ssc) && (m_gid[2] <= c_spt);
                  if (m_gid_valid) media_start(m_gid[2] - 8'd1);
                  m_phase = fdc_pkg::PH_NONE;
                  m_sec_done = 0;
                end
              end else if (m_phase == fdc_pkg::PH_DATA && m_gid_valid) begin
                op_code = fdc_pkg::MOP_WRITE;
                op_wb = v;
                m_sec_done++;
                if (m_sec_done == (128 << c_ssc)) begin
                  m_sec_done = 0; m_gid_valid = 1'b0; m_phase = fdc_pkg::PH_NONE;
                end
              end
              m_trk_bytes++;
              if (m_trk_bytes < int'(fdc_pkg::TRACK_WRITE_LIMIT)) begin
                m_sts = ST_ACTIVE;
              end else begin
                m_mode = fdc_pkg::MODE_WAIT; m_sts = '0; m_irq = 1'b1;
              end
            end else begin
              op_code = fdc_pkg::MOP_WRITE;
              op_wb = v;
              if (it.media_last_byte) begin
                if (m_last_cmd == fdc_pkg::CMD_WR_M) begin
                  media_start(m_sec);
                  m_sec = m_sec + 8'd1;
                  m_sts = ST_ACTIVE;
                end else begin
                  m_mode = fdc_pkg::MODE_WAIT; m_sts = '0;
                end
              end
            end
          end
        end
      endcase
    end else begin
      case (it.reg_addr)
        fdc_pkg::REG_CMD: begin
          m_irq = 1'b0;
          if (!it.drive_attached || !it.media_present) m_sts = m_sts | ST_NOT_RDY;
          else m_sts = m_sts & ~ST_NOT_RDY;
          type1 = (m_last_cmd < fdc_pkg::CMD_RD) || (m_last_cmd == fdc_pkg::CMD_FINT);
          if (type1) begin
            if (it.time_us % fdc_pkg::INDEX_PERIOD < fdc_pkg::INDEX_WIDTH)
              m_sts = m_sts | ST_DRQ_IDX;
            else m_sts = m_sts & ~ST_DRQ_IDX;
          end
          dt = it.time_us - m_cmd_time;
          if (m_last_cmd == fdc_pkg::CMD_RADDR && dt > fdc_pkg::RADDR_TIMEOUT)
            m_sts = m_sts & ~ST_BUSY;
          rd = m_sts;
          if (m_last_cmd == fdc_pkg::CMD_RESTORE) m_sts = ST_IDLE_TK0;
          else if (type1) m_sts = (m_trk == 0) ? ST_IDLE_TK0 : ST_IDLE;
        end
        fdc_pkg::REG_TRK: rd = m_trk;
        fdc_pkg::REG_SEC: rd = m_sec;
        default: begin
          if (m_mode == fdc_pkg::MODE_WAIT) m_sts = m_sts & ~ST_DRQ_IDX;
          if (m_mode == fdc_pkg::MODE_READ) begin
            if (m_id_left > 0) begin
              m_dat = m_id_buf[6 - m_id_left];
              m_id_left--;
              if (m_id_left == 0) begin
                m_mode = fdc_pkg::MODE_WAIT; m_sts = '0;
              end
            end else if (it.drive_attached) begin
              m_dat = it.media_byte;
              op_code = fdc_pkg::MOP_CONSUME;
              if (it.media_last_byte) begin
                if (m_last_cmd == fdc_pkg::CMD_RD_M) begin
                  media_start(m_sec);
                  m_sec = m_sec + 8'd1;
                  m_sts = ST_BUSY;
                end else begin
                  m_mode = fdc_pkg::MODE_WAIT; m_sts = '0;
                end
              end
            end
          end
          rd = m_dat;
        end
      endcase
    end
    if (op_start)
      op_code = (op_code == fdc_pkg::MOP_NONE) ? fdc_pkg::MOP_START : op_code + 3'd2;
    r = '0;
    r.read_data = rd;
    r.irq = m_irq;
    r.drq = (m_mode != fdc_pkg::MODE_WAIT);
    r.media_op = op_code;
    r.media_sector_index = op_idx;
    r.media_track = op_trk;
    r.media_head = op_hd;
    r.media_write_byte = (op_code == fdc_pkg::MOP_WRITE ||
                          op_code == fdc_pkg::MOP_WRITE + 3'd2) ? op_wb : '0;
    r.media_drive = (op_code != fdc_pkg::MOP_NONE) ? c_drive : '0;
  endtask

  task automatic report_mismatch(string field, int got, int exp);
    mismatch_count++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_checked, field, got, exp);
  endtask

  task automatic check_result(fdc_pkg::out_item_t got, fdc_pkg::out_item_t exp);
    if (got.read_data != exp.read_data)
      report_mismatch("read_data", got.read_data, exp.read_data);
    if (got.irq != exp.irq) report_mismatch("irq", got.irq, exp.irq);
    if (got.drq != exp.drq) report_mismatch("drq", got.drq, exp.drq);
    if (got.media_op != exp.media_op)
      report_mismatch("media_op", got.media_op, exp.media_op);
    if (got.media_sector_index != exp.media_sector_index)
      report_mismatch("media_sector_index", got.media_sector_index, exp.media_sector_index);
    if (got.media_track != exp.media_track)
      report_mismatch("media_track", got.media_track, exp.media_track);
    if (got.media_head != exp.media_head)
      report_mismatch("media_head", got.media_head, exp.media_head);
    if (got.media_write_byte != exp.media_write_byte)
      report_mismatch("media_write_byte", got.media_write_byte, exp.media_write_byte);
    if (got.media_drive != exp.media_drive)
      report_mismatch("media_drive", got.media_drive, exp.media_drive);
  endtask

  // result side: compare every accepted transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("[%0t] result with no access outstanding", $realtime);
      end else begin
        check_result(out_data, pending_results.pop_front());
      end
      results_checked++;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // end the run after a long stretch with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_access(input fdc_pkg::in_item_t it, input bit typed,
                             input fdc_pkg::out_item_t typed_exp);
    fdc_pkg::out_item_t e;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    predict_access(it, e);
    pending_results.push_back(typed ? typed_exp : e);
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic send(input fdc_pkg::in_item_t it);
    send_access(it, 1'b0, '0);
  endtask

  function automatic fdc_pkg::in_item_t dir_access(bit k, logic [1:0] a, logic [7:0] v);
    fdc_pkg::in_item_t it;
    it = '0;
    it.kind = k; it.reg_addr = a; it.write_value = v;
    it.time_us = 32'd5000;
    it.drive_attached = 1'b1; it.media_present = 1'b1;
    return it;
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 21474) * fdc_pkg::INDEX_PERIOD + $urandom_range(0, 3100);
      2: return m_cmd_time + $urandom_range(299000, 301000);
      default: return m_cmd_time + $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic fdc_pkg::in_item_t rnd_access(bit k, logic [1:0] a, logic [7:0] v);
    fdc_pkg::in_item_t it;
    it.kind = k; it.reg_addr = a; it.write_value = v;
    it.time_us = pick_time();
    it.drive_attached = ($urandom_range(0, 15) != 0);
    it.media_present = ($urandom_range(0, 15) != 0);
    it.write_protect = ($urandom_range(0, 3) == 0);
    it.media_byte = 8'($urandom);
    it.media_last_byte = ($urandom_range(0, 5) == 0);
    it.media_sector_under_head = 8'($urandom);
    return it;
  endfunction

  task automatic add_row(fdc_pkg::in_item_t it, bit typed = 1'b0,
                         fdc_pkg::out_item_t exp = '0);
    dir_row_t row;
    row.acc = it; row.typed = typed; row.exp = exp;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    fdc_pkg::in_item_t it;
    add_row(dir_access(1'b0, fdc_pkg::REG_SEC, 8'h00), 1'b1,
            '{read_data: 8'h01, default: '0});
    add_row(dir_access(1'b0, fdc_pkg::REG_TRK, 8'h00), 1'b1, '{default: '0});
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h00), 1'b1, '{irq: 1'b1, default: '0});
    add_row(dir_access(1'b0, fdc_pkg::REG_CMD, 8'h00), 1'b1,
            '{read_data: ST_BUSY, default: '0});
    add_row(dir_access(1'b1, fdc_pkg::REG_DATA, 8'hFF));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h10));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h50));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h7F));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h20));
    it = dir_access(1'b0, fdc_pkg::REG_CMD, 8'h00);
    it.time_us = 32'hFFFF_FFFF; it.media_present = 1'b0;
    add_row(it);
    add_row(dir_access(1'b1, fdc_pkg::REG_SEC, 8'h00));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h80));
    it = dir_access(1'b0, fdc_pkg::REG_DATA, 8'h00);
    it.media_byte = 8'hFF; it.media_last_byte = 1'b1;
    add_row(it);
    add_row(dir_access(1'b1, fdc_pkg::REG_SEC, 8'hFF));
    add_row(dir_access(1'b1, fdc_pkg::REG_SEC, 8'h05));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'h90));
    add_row(it);
    it = dir_access(1'b1, fdc_pkg::REG_CMD, 8'hA0);
    it.write_protect = 1'b1;
    add_row(it);
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'hB0));
    it = dir_access(1'b1, fdc_pkg::REG_DATA, 8'h00);
    it.media_last_byte = 1'b1;
    add_row(it);
    it = dir_access(1'b1, fdc_pkg::REG_CMD, 8'hC0);
    it.time_us = 32'hFFFF_FF00; it.media_sector_under_head = 8'hFF;
    add_row(it);
    add_row(dir_access(1'b0, fdc_pkg::REG_DATA, 8'h00));
    add_row(dir_access(1'b0, fdc_pkg::REG_DATA, 8'h00));
    it = dir_access(1'b0, fdc_pkg::REG_CMD, 8'h00);
    it.time_us = 32'd300000;
    add_row(it);
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, {CMD_SPARE, 4'h0}));
    it = dir_access(1'b1, fdc_pkg::REG_CMD, 8'h80);
    it.drive_attached = 1'b0;
    add_row(it);
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, 8'hD0));
    add_row(dir_access(1'b1, fdc_pkg::REG_CMD, {fdc_pkg::CMD_WTRK, 4'h0}));
    add_row(dir_access(1'b1, fdc_pkg::REG_DATA, fdc_pkg::MARK_ID));
    add_row(dir_access(1'b1, fdc_pkg::REG_DATA, fdc_pkg::MARK_CRC));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      fdc_pkg::CFG_DRIVE: c_drive = val[1:0];
      fdc_pkg::CFG_HEAD:  c_head = val[0];
      fdc_pkg::CFG_SPT:   c_spt = val;
      default:            c_ssc = val[1:0];
    endcase
  endtask

  // one write-track session of ID and data fields
  task automatic format_track(int extra_bytes);
    int n;
    logic [7:0] fld;
    send(rnd_access(1'b1, fdc_pkg::REG_CMD, {fdc_pkg::CMD_WTRK, 4'($urandom)}));
    repeat ($urandom_range(1, 3)) begin
      send(rnd_access(1'b1, fdc_pkg::REG_DATA, fdc_pkg::MARK_ID));
      for (int i = 0; i < 4; i++) begin
        case (i)
          0: fld = ($urandom_range(0, 7) == 0) ? 8'($urandom) : m_trk;
          1: fld = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {7'd0, c_head};
          2: fld = 8'($urandom_range(0, int'(c_spt) + 1));
          default: fld = {6'($urandom), ($urandom_range(0, 7) == 0) ? 2'($urandom) : c_ssc};
        endcase
        send(rnd_access(1'b1, fdc_pkg::REG_DATA, fld));
      end
      send(rnd_access(1'b1, fdc_pkg::REG_DATA, fdc_pkg::MARK_CRC));
      send(rnd_access(1'b1, fdc_pkg::REG_DATA, fdc_pkg::MARK_DATA));
      n = (c_ssc < 2 && $urandom_range(0, 2) == 0) ? (128 << c_ssc) + 1 : $urandom_range(1, 20);
      repeat (n) send(rnd_access(1'b1, fdc_pkg::REG_DATA, 8'($urandom)));
      send(rnd_access(1'b1, fdc_pkg::REG_DATA, fdc_pkg::MARK_CRC));
    end
    repeat (extra_bytes) send(rnd_access(1'b1, fdc_pkg::REG_DATA, 8'($urandom)));
    send(rnd_access(1'b0, fdc_pkg::REG_CMD, 8'h00));
  endtask

  task automatic random_sequence();
    logic [3:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 1))
          send(rnd_access(1'b1, fdc_pkg::REG_DATA, 8'($urandom)));
        send(rnd_access(1'b1, fdc_pkg::REG_CMD, {4'($urandom_range(0, 7)), 4'($urandom)}));
        send(rnd_access(1'b0, fdc_pkg::REG_CMD, 8'h00));
        send(rnd_access(1'b0, fdc_pkg::REG_TRK, 8'h00));
      end
      2, 3, 4: begin
        c = 4'($urandom_range(int'(fdc_pkg::CMD_RD), int'(fdc_pkg::CMD_WR_M)));
        send(rnd_access(1'b1, fdc_pkg::REG_SEC,
                        ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, int'(c_spt) + 1))));
        send(rnd_access(1'b1, fdc_pkg::REG_CMD, {c, 4'($urandom)}));
        repeat ($urandom_range(1, 12))
          send(rnd_access(c >= fdc_pkg::CMD_WR, fdc_pkg::REG_DATA, 8'($urandom)));
        send(rnd_access(1'b0, fdc_pkg::REG_CMD, 8'h00));
        send(rnd_access(1'b0, fdc_pkg::REG_SEC, 8'h00));
      end
      5, 6: begin
        send(rnd_access(1'b1, fdc_pkg::REG_CMD, {fdc_pkg::CMD_RADDR, 4'($urandom)}));
        repeat ($urandom_range(1, 8)) send(rnd_access(1'b0, fdc_pkg::REG_DATA, 8'h00));
        send(rnd_access(1'b0, fdc_pkg::REG_CMD, 8'h00));
      end
      7: format_track(0);
      8: send(rnd_access(1'b1, fdc_pkg::REG_CMD, {fdc_pkg::CMD_FINT, 4'($urandom)}));
      default: begin
        repeat ($urandom_range(1, 4))
          send(rnd_access(1'($urandom), 2'($urandom), 8'($urandom)));
      end
    endcase
  endtask

  initial begin
    int phase_budget;
    int start_count;
    int spt_choice [NUM_PHASES] = '{1, 255, 5, 2, 3, 255, 1, 4};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    accesses_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    build_directed();
    foreach (directed_rows[i]) send_access(directed_rows[i].acc, directed_rows[i].typed,
                                           directed_rows[i].exp);
    in_valid = 1'b0;

    phase_budget = RANDOM_ACCESSES / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case (p % 4)
        1: send_idle_pct = 53;
        2: recv_stall_pct = 53;
        3: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
        default: ;
      endcase
      write_cfg(fdc_pkg::CFG_DRIVE, (p == 0) ? 8'd3 : 8'($urandom));
      write_cfg(fdc_pkg::CFG_HEAD, {7'd0, p[0]});
      write_cfg(fdc_pkg::CFG_SPT, 8'(spt_choice[p]));
      write_cfg(fdc_pkg::CFG_SSC, (p < 2) ? 8'(p * 3) : 8'($urandom_range(0, 1)));
      start_count = accesses_sent;
      while (accesses_sent - start_count < phase_budget) random_sequence();
      in_valid = 1'b0;
    end

    wait_drained();
    $display("Ran %0d accesses over %0d configuration phases, %0d results checked",
             accesses_sent, NUM_PHASES, results_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
